// File: hdl/clta_pkg.sv
// Shared codes and control/status types for the cluster link table allocator.
package clta_pkg;

	// Request opcodes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FIND  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNMOUNTED = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_NOFREE    = 2'd3;

	// Result value source
	localparam logic [1:0] VSEL_ZERO  = 2'd0;
	localparam logic [1:0] VSEL_LAST  = 2'd1;
	localparam logic [1:0] VSEL_RDATA = 2'd2;
	localparam logic [1:0] VSEL_ADDR  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_MOUNTED = 1'b0;
	localparam logic CFG_COUNT   = 1'b1;

	// Link values
	localparam logic [31:0] LINK_FREE = 32'h0000_0000;
	localparam logic [31:0] LINK_LAST = 32'hFFFF_FFFF;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       capture;
		logic       clr_step;
		logic       wr_req;
		logic       mod_ld;
		logic       mod_step;
		logic       scan_init;
		logic       scan_issue;
		logic       save_group;
		logic       finish;
		logic [1:0] fin_status;
		logic [1:0] fin_vsel;
	} clta_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic       clr_done;
		logic       mounted;
		logic [1:0] op;
		logic       idx_bad;
		logic       used_zero;
		logic       mod_ge;
		logic       left_zero;
		logic       rd_vld;
		logic       hit;
	} clta_sts_t;

endpackage

// File: hdl/clta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/clta_dp.sv
// Datapath: config registers, request latch, table RAM, clear sweep, next-fit scan.
module clta_dp #(
	parameter int TABLE_DEPTH = 4096,
	parameter int GROUP_SIZE  = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  clta_pkg::clta_cmd_t            cmd,
	output clta_pkg::clta_sts_t            sts,
	input  logic [1:0]                     op,
	input  logic [$clog2(TABLE_DEPTH)-1:0] cluster_index,
	input  logic [31:0]                    link_value,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [$clog2(TABLE_DEPTH):0]   cfg_data,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [31:0]                    result_value
);
	import clta_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int LOG_G  = $clog2(GROUP_SIZE);
	localparam int NGRP   = TABLE_DEPTH / GROUP_SIZE;
	localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int GCNT_W = $clog2(NGRP + 1);

	// Config registers
	logic             mounted_q;
	logic [CNT_W-1:0] count_q;

	// Latched request
	logic [1:0]       req_op_q;
	logic [IDX_W-1:0] req_idx_q;
	logic [31:0]      req_val_q;

	// Search state
	logic [GRP_W-1:0] ng_q;
	logic [GRP_W-1:0] ng_work_q;
	logic [IDX_W-1:0] scan_addr_q;
	logic [CNT_W-1:0] scan_left_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	logic [IDX_W-1:0] clr_addr_q;

	// Result registers
	logic             done_q;
	logic [1:0]       status_q;
	logic [31:0]      value_q;

	logic [CNT_W-1:0]  used;
	logic [CNT_W:0]    gsum;
	logic [GCNT_W-1:0] groups;
	logic [IDX_W-1:0]  scan_next;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [31:0]       ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [31:0]       ram_rdata;
	logic              hit;

	// Effective cluster count and group count
	assign used   = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;
	assign gsum   = {1'b0, used} + (CNT_W + 1)'(GROUP_SIZE - 1);
	assign groups = GCNT_W'(gsum >> LOG_G);

	// Scan address wraps at the end of the clusters in use
	assign scan_next = (({1'b0, scan_addr_q} + CNT_W'(1)) == used) ? '0
		: scan_addr_q + IDX_W'(1);

	assign hit = rd_vld_s1 && (ram_rdata == LINK_FREE);

	// RAM port steering
	assign ram_we    = cmd.clr_step | cmd.wr_req;
	assign ram_waddr = cmd.clr_step ? clr_addr_q : req_idx_q;
	assign ram_wdata = cmd.clr_step ? ((clr_addr_q == '0) ? LINK_LAST : LINK_FREE)
		: req_val_q;
	assign ram_raddr = cmd.scan_issue ? scan_addr_q : req_idx_q;

	clta_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mounted_q <= 1'b0;
			count_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOUNTED: mounted_q <= cfg_data[0];
				CFG_COUNT:   count_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Request latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q  <= op;
			req_idx_q <= cluster_index;
			req_val_q <= link_value;
		end
	end

	// Clear sweep address and saved start group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			ng_q       <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
			if (cmd.save_group) begin
				ng_q <= GRP_W'(rd_addr_s1 >> LOG_G);
			end
		end
	end

	// Start-group reduction and scan counters
	always_ff @(posedge clk) begin
		if (cmd.mod_ld) begin
			ng_work_q <= ng_q;
		end else if (cmd.mod_step) begin
			ng_work_q <= ng_work_q - GRP_W'(groups);
		end
		if (cmd.scan_init) begin
			scan_addr_q <= IDX_W'(ng_work_q) << LOG_G;
			scan_left_q <= used;
		end else if (cmd.scan_issue) begin
			scan_addr_q <= scan_next;
			scan_left_q <= scan_left_q - CNT_W'(1);
		end
		if (cmd.scan_issue) begin
			rd_addr_s1 <= scan_addr_q;
		end
	end

	// Read-in-flight flag, aligned with RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_issue;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			case (cmd.fin_vsel)
				VSEL_ZERO:  value_q <= 32'd0;
				VSEL_LAST:  value_q <= LINK_LAST;
				VSEL_RDATA: value_q <= ram_rdata;
				VSEL_ADDR:  value_q <= 32'(rd_addr_s1);
				default:    value_q <= 32'd0;
			endcase
		end
	end

	// Status to controller
	always_comb begin
		sts           = '0;
		sts.clr_done  = (clr_addr_q == '1);
		sts.mounted   = mounted_q;
		sts.op        = req_op_q;
		sts.idx_bad   = ({1'b0, req_idx_q} >= used);
		sts.used_zero = (used == '0);
		sts.mod_ge    = (GCNT_W'(ng_work_q) >= groups);
		sts.left_zero = (scan_left_q == '0);
		sts.rd_vld    = rd_vld_s1;
		sts.hit       = hit;
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_value = value_q;

	// Results are single-cycle strobes, never back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	// A failed search always reports the last-cluster marker
	a_nofree_val: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_NOFREE) |-> (value_q == LINK_LAST))
		else $error("no-free result without last marker");

	// A found cluster must be a free entry read during the scan
	a_hit_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.save_group |-> (rd_vld_s1 && ram_rdata == LINK_FREE))
		else $error("start group saved without a free hit");

endmodule

// File: hdl/clta_ctrl.sv
// Controller: sequences clear sweep, request decode, reads, writes and the free search.
module clta_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  clta_pkg::clta_sts_t sts,
	output clta_pkg::clta_cmd_t cmd
);
	import clta_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_RDW  = 3'd3;
	localparam logic [2:0] S_MOD  = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				state_d        = S_IDLE;
				cmd.finish     = 1'b1;
				cmd.fin_status = ST_RANGE;
				cmd.fin_vsel   = VSEL_ZERO;
				if (!sts.mounted) begin
					cmd.fin_status = ST_UNMOUNTED;
					cmd.fin_vsel   = (sts.op == OP_FIND) ? VSEL_LAST : VSEL_ZERO;
				end else begin
					case (sts.op)
						OP_READ: begin
							// read was issued this cycle from the latched index
							if (!sts.idx_bad) begin
								cmd.finish = 1'b0;
								state_d    = S_RDW;
							end
						end
						OP_WRITE: begin
							if (!sts.idx_bad) begin
								cmd.wr_req     = 1'b1;
								cmd.fin_status = ST_OK;
							end
						end
						OP_FIND: begin
							if (sts.used_zero) begin
								cmd.fin_status = ST_NOFREE;
								cmd.fin_vsel   = VSEL_LAST;
							end else begin
								cmd.finish = 1'b0;
								cmd.mod_ld = 1'b1;
								state_d    = S_MOD;
							end
						end
						default: ;
					endcase
				end
			end
			S_RDW: begin
				cmd.finish     = 1'b1;
				cmd.fin_status = ST_OK;
				cmd.fin_vsel   = VSEL_RDATA;
				state_d        = S_IDLE;
			end
			S_MOD: begin
				// reduce a stale start group modulo the group count
				if (sts.mod_ge) begin
					cmd.mod_step = 1'b1;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_OK;
					cmd.fin_vsel   = VSEL_ADDR;
					cmd.save_group = 1'b1;
					state_d        = S_IDLE;
				end else if (sts.left_zero && !sts.rd_vld) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_NOFREE;
					cmd.fin_vsel   = VSEL_LAST;
					state_d        = S_IDLE;
				end else begin
					cmd.scan_issue = !sts.left_zero;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// An accepted transaction keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// Scan reads are only issued while entries remain
	a_issue_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> !sts.left_zero)
		else $error("scan read issued past the end");

	// The table is written only by the sweep or a checked write
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_req |-> (sts.mounted && !sts.idx_bad && sts.op == OP_WRITE))
		else $error("unchecked table write");

endmodule

// File: hdl/cluster_link_table_allocator.sv
// Top level: cluster link table with read, write and next-fit free-cluster search.
// Reads return the table entry; writes and rejects finish after decode. A search first
// reduces the saved start group modulo the group count, then scans entries from that group
// until a free one is found or all are read. One transaction at a time; the next start is
// taken in the cycle that done is high, and done cannot be stalled. Reset: the table is
// swept (entry 0 = last marker, rest free) with busy high.
module cluster_link_table_allocator #(
	parameter int TABLE_DEPTH = 4096,
	parameter int GROUP_SIZE  = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     op,
	input  logic [$clog2(TABLE_DEPTH)-1:0] cluster_index,
	input  logic [31:0]                    link_value,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [$clog2(TABLE_DEPTH):0]   cfg_data,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [31:0]                    result_value
);
	import clta_pkg::*;

	clta_cmd_t cmd;
	clta_sts_t sts;

	clta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	clta_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.GROUP_SIZE  (GROUP_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.cluster_index (cluster_index),
		.link_value    (link_value),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.result_value  (result_value)
	);

endmodule

// File: sim/clta_checker.sv
// Checker for the cluster link table allocator: predicts each reply and compares it.
module clta_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [11:0] cluster_index,
	input  logic [31:0] link_value,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] result_value,
	output int          mismatch_count,
	output int          replies_pending
);
	import clta_pkg::*;

	localparam int unsigned DEPTH = 4096;
	localparam int unsigned GROUP = 128;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
	} reply_t;

	// Shadow copy of the table, search pointer and registers
	logic [31:0] link_shadow [DEPTH];
	logic [4:0]  search_group;
	logic        is_mounted;
	logic [12:0] clusters_in_use;

	reply_t expected_replies [$];
	reply_t got_reply;
	reply_t want_reply;

	initial mismatch_count = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: reply mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Apply one request to the shadow state and return the reply it must give
	function automatic reply_t serve_request(input logic [1:0] req_op,
			input logic [11:0] idx, input logic [31:0] val);
		reply_t      r;
		int unsigned used;
		int unsigned groups;
		int unsigned g;
		int unsigned base;
		int unsigned span;
		used = (clusters_in_use > DEPTH) ? DEPTH : clusters_in_use;
		r.status = ST_OK;
		r.value  = '0;
		if (!is_mounted) begin
			r.status = ST_UNMOUNTED;
			r.value  = (req_op == OP_FIND) ? LINK_LAST : '0;
			return r;
		end
		if (req_op == OP_READ || req_op == OP_WRITE) begin
			if (idx >= used) begin
				r.status = ST_RANGE;
			end else if (req_op == OP_READ) begin
				r.value = link_shadow[idx];
			end else begin
				link_shadow[idx] = val;
			end
			return r;
		end
		if (req_op == OP_FIND) begin
			groups = (used + GROUP - 1) / GROUP;
			// next-fit: start at the last hit group, wrap over groups in use
			for (int unsigned i = 0; i < groups; i++) begin
				g    = (search_group + i) % groups;
				base = g * GROUP;
				span = used - base;
				if (span > GROUP)
					span = GROUP;
				for (int unsigned j = 0; j < span; j++) begin
					if (link_shadow[base + j] == LINK_FREE) begin
						search_group = g[4:0];
						r.value = base + j;
						return r;
					end
				end
			end
			r.status = ST_NOFREE;
			r.value  = LINK_LAST;
			return r;
		end
		// undefined opcode
		r.status = ST_RANGE;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_replies.delete();
			for (int i = 0; i < DEPTH; i++)
				link_shadow[i] = LINK_FREE;
			link_shadow[0] = LINK_LAST;
			search_group    = '0;
			is_mounted      = 1'b0;
			clusters_in_use = '0;
			replies_pending <= 0;
		end else begin
			// compare a reply with the oldest prediction
			if (done) begin
				got_reply.status = status;
				got_reply.value  = result_value;
				if (expected_replies.size() == 0) begin
					report_mismatch("reply with no request outstanding", got_reply.value, '0);
				end else begin
					want_reply = expected_replies.pop_front();
					if (got_reply.status !== want_reply.status)
						report_mismatch("status", 32'(got_reply.status),
							32'(want_reply.status));
					if (got_reply.value !== want_reply.value)
						report_mismatch("result_value", got_reply.value, want_reply.value);
				end
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == CFG_MOUNTED)
					is_mounted = cfg_data[0];
				else
					clusters_in_use = cfg_data;
			end
			// accepted transaction
			if (start && !busy)
				expected_replies.push_back(serve_request(op, cluster_index, link_value));
			replies_pending <= expected_replies.size();
		end
	end

endmodule

// File: sim/testbench.sv
// Testbench top: stimulus, register setup and verdict for the cluster link table allocator.
module testbench;
	import clta_pkg::*;

	localparam int         STALL_LIMIT = 20000;
	localparam logic [1:0] OP_UNDEF    = 2'd3;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic [1:0]  op            = OP_READ;
	logic [11:0] cluster_index = '0;
	logic [31:0] link_value    = '0;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = CFG_MOUNTED;
	logic [12:0] cfg_data      = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [31:0] result_value;
	int          mismatch_count;
	int          replies_pending;
	int          stall_cycles  = 0;
	bit          idling_on     = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cluster_link_table_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.cluster_index(cluster_index),
		.link_value   (link_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.status       (status),
		.result_value (result_value)
	);

	clta_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.cluster_index  (cluster_index),
		.link_value     (link_value),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.result_value   (result_value),
		.mismatch_count (mismatch_count),
		.replies_pending(replies_pending)
	);

	// Watchdog: cycles with no transaction and no reply
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Present one request and hold it until accepted; start stays high
	task automatic send_request(input logic [1:0] req_op, input logic [11:0] idx,
			input logic [31:0] val);
		start         <= 1'b1;
		op            <= req_op;
		cluster_index <= idx;
		link_value    <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Wait for the reply of the transaction just accepted
	task automatic get_reply(output logic [1:0] st, output logic [31:0] rv);
		start <= 1'b0;
		do
			@(posedge clk);
		while (!done);
		st = status;
		rv = result_value;
	endtask

	// Hold off until the block is idle and every reply is in
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (busy || replies_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [12:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic maybe_idle();
		if (idling_on && $urandom_range(0, 5) == 0)
			pause($urandom_range(1, 17));
	endtask

	function automatic logic [31:0] pick_link();
		case ($urandom_range(0, 3))
			0:       return LINK_FREE;
			1:       return LINK_LAST;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request(input int eff);
		logic [1:0]  req_op;
		logic [11:0] idx;
		req_op = ($urandom_range(0, 15) == 0) ? OP_UNDEF : 2'($urandom_range(0, 2));
		if (eff > 0 && $urandom_range(0, 3) != 0)
			idx = 12'($urandom_range(0, eff - 1));
		else
			idx = 12'($urandom_range(0, 4095));
		send_request(req_op, idx, pick_link());
	endtask

	// Allocate a short chain: find a free cluster, then link it and a few after it
	task automatic alloc_chain(input int eff, output int issued);
		logic [1:0]  st;
		logic [31:0] found;
		logic [31:0] v;
		int          len;
		send_request(OP_FIND, 12'($urandom), $urandom);
		get_reply(st, found);
		issued = 1;
		if (st == ST_OK) begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++) begin
				if (found + i < eff) begin
					v = ($urandom_range(0, 3) == 0) ? LINK_LAST : $urandom;
					if (v == LINK_FREE)
						v = 32'd1;
					send_request(OP_WRITE, 12'(found + i), v);
					issued++;
					maybe_idle();
				end
			end
		end
	endtask

	// One setting of the registers followed by a mix of chains and loose requests
	task automatic run_phase(input logic mnt, input int count, input int n_items,
			input int fill_pct, input bit idle_en);
		int eff;
		int n;
		int issued;
		drain();
		write_reg(CFG_MOUNTED, 13'(mnt));
		write_reg(CFG_COUNT, 13'(count));
		idling_on = idle_en;
		eff = (count > 4096) ? 4096 : count;
		n = 0;
		while (n < n_items) begin
			if ($urandom_range(0, 99) < fill_pct) begin
				alloc_chain(eff, issued);
				n += issued;
			end else begin
				random_request(eff);
				n++;
			end
			maybe_idle();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// unmounted: everything fails, nothing changes
		send_request(OP_READ, 12'd0, 32'd0);
		send_request(OP_WRITE, 12'd5, 32'd123);
		send_request(OP_FIND, 12'd0, 32'd0);
		send_request(OP_UNDEF, 12'hFFF, 32'hFFFF_FFFF);

		// mounted with no clusters in use
		drain();
		write_reg(CFG_MOUNTED, 13'd1);
		write_reg(CFG_COUNT, 13'd0);
		send_request(OP_FIND, 12'd0, 32'd0);
		send_request(OP_READ, 12'd0, 32'd0);
		send_request(OP_WRITE, 12'd0, 32'h1234_5678);

		// full table
		drain();
		write_reg(CFG_COUNT, 13'd4096);
		send_request(OP_READ, 12'd0, 32'd0);
		send_request(OP_READ, 12'hFFF, 32'd0);
		send_request(OP_WRITE, 12'hFFF, LINK_LAST);
		send_request(OP_READ, 12'hFFF, 32'd0);
		send_request(OP_READ, 12'd5, 32'd0);
		send_request(OP_WRITE, 12'd1, 32'hA5A5_5A5A);
		send_request(OP_FIND, 12'd0, 32'd0);
		send_request(OP_UNDEF, 12'hFFF, 32'hFFFF_FFFF);
		send_request(OP_WRITE, 12'd1, LINK_FREE);
		send_request(OP_FIND, 12'd0, 32'd0);

		// oversized count is clamped to the table depth
		drain();
		write_reg(CFG_COUNT, 13'h1FFF);
		send_request(OP_READ, 12'hFFF, 32'd0);
		send_request(OP_WRITE, 12'hFFF, LINK_FREE);
		send_request(OP_FIND, 12'd0, 32'd0);

		// exactly one full group
		drain();
		write_reg(CFG_COUNT, 13'd128);
		send_request(OP_READ, 12'd127, 32'd0);
		send_request(OP_READ, 12'd128, 32'd0);
		send_request(OP_WRITE, 12'd127, 32'h8000_0001);
		send_request(OP_FIND, 12'd0, 32'd0);

		// random part: fill past the first group, then shrink so the search group wraps
		run_phase(1'b1, 130, 240, 90, 1'b1);
		run_phase(1'b1, $urandom_range(1, 128), 80, 60, 1'b1);
		run_phase(1'b1, 4096, 100, 50, 1'b0);
		run_phase(1'b0, 300, 30, 30, 1'b1);
		run_phase(1'b1, $urandom_range(129, 700), 120, 60, 1'b1);
		run_phase(1'b1, 8191, 60, 40, 1'b1);
		run_phase(1'b1, $urandom_range(1, 12), 80, 70, 1'b1);
		run_phase(1'b1, $urandom_range(0, 4096), 120, 60, 1'($urandom_range(0, 1)));
		run_phase(1'b1, $urandom_range(200, 1200), 100, 60, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && replies_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
hdl/clta_pkg.sv
hdl/clta_ram.sv
hdl/clta_dp.sv
hdl/clta_ctrl.sv
hdl/cluster_link_table_allocator.sv
sim/clta_checker.sv
sim/testbench.sv
